FILE: hdl/sha256_byte_stream_hasher_unit_macros.svh
// Assertion macros used by the SHA-256 hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHABSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHABSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/shabsh_pkg.sv
// Types and constants of the SHA-256 byte stream hasher.
package shabsh_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned FILL_W    = 6;
  localparam int unsigned COUNT_W   = 61;
  localparam int unsigned BLK_AW    = 4;
  localparam int unsigned RND_W     = 6;

  localparam logic [IDX_W-1:0]  LAST_WORD_IDX = 3'd7;
  localparam logic [IDX_W-1:0]  PENULT_IDX    = 3'd6;
  localparam logic [BYTE_W-1:0] PAD_BYTE      = 8'h80;
  // Fill level from which the length no longer fits in the current block.
  localparam logic [FILL_W-1:0] LEN_LIMIT     = 6'd56;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

FILE: hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 over a byte stream: one input transaction per message byte, one output
// transaction per digest word. Bytes are taken one per cycle while the block buffer
// fills; every 64th byte starts a compression (the working variables are loaded
// from the hash memory, 64 rounds run at one per cycle, and the working variables
// are added back into the hash memory) during which no input is taken. A
// transaction with tlast set closes the message: the padding words are written into
// the block memory at one word a cycle, one or two more compressions follow, and the
// eight digest words leave h0 first. The hash words and the block buffer live in two
// small synchronous memories with registered read data; the hash memory reads back
// as the initial hash values after reset and after every digest, so no clearing
// pass is needed. The last digest word waiting on m_axis does not hold off the next
// message.
module sha256_byte_stream_hasher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [shabsh_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                           s_axis_tuser,   // [0] byte_valid
  input  logic                           s_axis_tlast,   // last_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [shabsh_pkg::WORD_W-1:0]  m_axis_tdata,   // [31:0] digest_word
  output logic [shabsh_pkg::IDX_W-1:0]   m_axis_tuser,   // [2:0] word_index
  output logic                           m_axis_tlast    // last_word
);
  import shabsh_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,    // taking message bytes
    S_PAD,     // writing padding / length words
    S_HINIT,   // hash memory -> working variables
    S_ROUND,   // 64 compression rounds
    S_HADD,    // working variables added into hash memory
    S_ORD,     // digest word read issued
    S_OWAIT    // digest word into output register
  } state_e;

  // Where to go once a compression is done.
  typedef enum logic [1:0] {
    RET_LOAD,  // plain full block
    RET_PAD1,  // message closed right on a block boundary
    RET_PAD2,  // length spills into a second padding block
    RET_OUT    // final block done, emit digest
  } ret_e;

  localparam logic [3:0] CntLast = 4'd8;
  localparam logic [3:0] LenHiWord = 4'd14;
  localparam logic [3:0] LenLoWord = 4'd15;

  // Round functions.
  function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Control registers.
  state_e               state_q, state_d;
  ret_e                 ret_q, ret_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [BLK_AW-1:0]    pw_q, pw_d;
  logic                 pad_len_q, pad_len_d;
  logic                 pad_first_q, pad_first_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [RND_W-1:0]     rnd_q, rnd_d;
  logic                 iv_q, iv_d;        // hash memory reads as initial values
  logic [IDX_W-1:0]     oidx_q, oidx_d;
  logic                 out_valid_q, out_valid_d;

  // Datapath registers.
  logic [23:0]          wacc_q, wacc_d;    // bytes of the partial word
  logic [WORD_W-1:0]    v_q  [8];
  logic [WORD_W-1:0]    v_d  [8];
  logic [WORD_W-1:0]    sw_q [16];         // schedule window, [15] newest
  logic [WORD_W-1:0]    sw_d [16];
  logic [WORD_W-1:0]    out_data_q, out_data_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;

  // Block memory: 16 big-endian words.
  logic [WORD_W-1:0]    bmem [16];
  logic                 bwe;
  logic [BLK_AW-1:0]    bwa, bra;
  logic [WORD_W-1:0]    bwd, brd_q;

  // Hash memory: h0..h7.
  logic [WORD_W-1:0]    hmem [8];
  logic                 hwe;
  logic [IDX_W-1:0]     hwa, hra, hra_q;
  logic [WORD_W-1:0]    hwd, hrd_q, hdat;
  logic                 hiv_q;

  logic                 in_fire, out_fire;
  logic [WORD_W-1:0]    w_t, t1, t2, ch, maj, pad_word;
  logic [63:0]          bit_len;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = (out_idx_q == LAST_WORD_IDX);

  always_ff @(posedge clk_i) begin
    if (bwe) begin
      bmem[bwa] <= bwd;
    end
    brd_q <= bmem[bra];
  end

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hmem[hwa] <= hwd;
    end
    hrd_q <= hmem[hra];
  end

  // Until the first write-back of a message the memory content is stale.
  assign hdat = hiv_q ? INIT_HASH[hra_q] : hrd_q;

  // Message schedule and round.
  always_comb begin
    if (rnd_q[RND_W-1:4] == '0) begin
      w_t = brd_q;
    end else begin
      w_t = ssig1(sw_q[14]) + sw_q[9] + ssig0(sw_q[1]) + sw_q[0];
    end
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd_q] + w_t;
    t2  = bsig0(v_q[0]) + maj;
  end

  assign bit_len = {count_q, 3'b000};

  // Padding word at pw_q; the first one merges 0..3 held bytes with 0x80.
  always_comb begin
    pad_word = '0;
    if (pad_first_q) begin
      case (fill_q[1:0])
        2'd0:    pad_word = {PAD_BYTE, 24'h0};
        2'd1:    pad_word = {wacc_q[7:0], PAD_BYTE, 16'h0};
        2'd2:    pad_word = {wacc_q[15:0], PAD_BYTE, 8'h0};
        2'd3:    pad_word = {wacc_q[23:0], PAD_BYTE};
        default: pad_word = '0;
      endcase
    end else if (pad_len_q && (pw_q == LenHiWord)) begin
      pad_word = bit_len[63:32];
    end else if (pad_len_q && (pw_q == LenLoWord)) begin
      pad_word = bit_len[31:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    count_d     = count_q;
    pw_d        = pw_q;
    pad_len_d   = pad_len_q;
    pad_first_d = pad_first_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    iv_d        = iv_q;
    oidx_d      = oidx_q;
    out_valid_d = out_valid_q;
    wacc_d      = wacc_q;
    v_d         = v_q;
    sw_d        = sw_q;
    out_data_d  = out_data_q;
    out_idx_d   = out_idx_q;
    bwe         = 1'b0;
    bwa         = fill_q[FILL_W-1:2];
    bwd         = pad_word;
    bra         = '0;
    hwe         = 1'b0;
    hwa         = cnt_q[IDX_W-1:0] - 3'd1;
    hwd         = hdat + v_q[0];
    hra         = cnt_q[IDX_W-1:0];

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (s_axis_tuser) begin
            fill_d  = fill_q + 6'd1;
            count_d = count_q + 61'd1;
            wacc_d  = {wacc_q[15:0], s_axis_tdata};
            if (fill_q[1:0] == 2'b11) begin
              bwe = 1'b1;
              bwd = {wacc_q, s_axis_tdata};
            end
          end
          if (s_axis_tuser && (fill_q == '1)) begin
            state_d = S_HINIT;
            cnt_d   = '0;
            ret_d   = s_axis_tlast ? RET_PAD1 : RET_LOAD;
          end else if (s_axis_tlast) begin
            state_d     = S_PAD;
            pw_d        = fill_d[FILL_W-1:2];
            pad_len_d   = (fill_d < LEN_LIMIT);
            pad_first_d = 1'b1;
          end
        end
      end

      S_PAD: begin
        bwe         = 1'b1;
        bwa         = pw_q;
        pad_first_d = 1'b0;
        pw_d        = pw_q + 4'd1;
        if (pw_q == '1) begin
          state_d = S_HINIT;
          cnt_d   = '0;
          ret_d   = pad_len_q ? RET_OUT : RET_PAD2;
        end
      end

      S_HINIT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != '0) begin
          for (int j = 0; j < 7; j++) begin
            v_d[j] = v_q[j+1];
          end
          v_d[7] = hdat;
        end
        if (cnt_q == CntLast) begin
          state_d = S_ROUND;
          rnd_d   = '0;
        end
      end

      S_ROUND: begin
        bra   = rnd_q[BLK_AW-1:0] + 4'd1;
        rnd_d = rnd_q + 6'd1;
        for (int j = 0; j < 15; j++) begin
          sw_d[j] = sw_q[j+1];
        end
        sw_d[15] = w_t;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        if (rnd_q == '1) begin
          state_d = S_HADD;
          cnt_d   = '0;
        end
      end

      S_HADD: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != '0) begin
          hwe = 1'b1;
          for (int j = 0; j < 7; j++) begin
            v_d[j] = v_q[j+1];
          end
          v_d[7] = v_q[0];
        end
        if (cnt_q == CntLast) begin
          iv_d = 1'b0;
          case (ret_q)
            RET_LOAD: begin
              state_d = S_LOAD;
            end
            RET_PAD1: begin
              state_d     = S_PAD;
              pw_d        = '0;
              pad_len_d   = 1'b1;
              pad_first_d = 1'b1;
            end
            RET_PAD2: begin
              state_d     = S_PAD;
              pw_d        = '0;
              pad_len_d   = 1'b1;
              pad_first_d = 1'b0;
            end
            RET_OUT: begin
              state_d = S_ORD;
              oidx_d  = '0;
            end
            default: begin
              state_d = S_LOAD;
            end
          endcase
        end
      end

      S_ORD: begin
        hra     = oidx_q;
        state_d = S_OWAIT;
      end

      S_OWAIT: begin
        hra = oidx_q;
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = hdat;
          out_idx_d   = oidx_q;
          oidx_d      = oidx_q + 3'd1;
          if (oidx_q == LAST_WORD_IDX) begin
            // Back to the initial hash values for the next message.
            state_d = S_LOAD;
            iv_d    = 1'b1;
            fill_d  = '0;
            count_d = '0;
          end else begin
            state_d = S_ORD;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ret_q       <= RET_LOAD;
      fill_q      <= '0;
      count_q     <= '0;
      pw_q        <= '0;
      pad_len_q   <= 1'b0;
      pad_first_q <= 1'b0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      iv_q        <= 1'b1;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      pw_q        <= pw_d;
      pad_len_q   <= pad_len_d;
      pad_first_q <= pad_first_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      iv_q        <= iv_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wacc_q     <= wacc_d;
    v_q        <= v_d;
    sw_q       <= sw_d;
    out_data_q <= out_data_d;
    out_idx_q  <= out_idx_d;
    hra_q      <= hra;
    hiv_q      <= iv_q;
  end

endmodule

FILE: hdl/shabsh_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
`include "sha256_byte_stream_hasher_unit_macros.svh"

module shabsh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [shabsh_pkg::BYTE_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [shabsh_pkg::WORD_W-1:0]  m_axis_tdata,
  input logic [shabsh_pkg::IDX_W-1:0]   m_axis_tuser,
  input logic                           m_axis_tlast
);
  import shabsh_pkg::*;

  logic out_stall, close_fire, early_word, last_ok;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign close_fire = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  // A digest word that is neither of the last two: more words must follow.
  assign early_word = m_axis_tvalid && m_axis_tready && !m_axis_tlast
                      && (m_axis_tuser != PENULT_IDX);
  assign last_ok    = (m_axis_tlast == (m_axis_tuser == LAST_WORD_IDX));

  `SHABSH_ASSERT_NXT(a_out_stall_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled digest word changed")
  `SHABSH_ASSERT_IMP(a_last_on_word7, m_axis_tvalid, last_ok, "tlast not on word 7")
  `SHABSH_ASSERT_NXT(a_close_busy, close_fire, !s_axis_tready, "input taken while padding")
  `SHABSH_ASSERT_NXT(a_digest_busy, early_word, !s_axis_tready, "input taken mid digest")

endmodule

bind sha256_byte_stream_hasher_unit shabsh_checker u_shabsh_checker (.*);
